>>> hdl/rss_pkg.sv
`default_nettype none

package rss_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // remainder unit: 32-bit dividend, DIV_BITS quotient bits per cycle
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = 32 / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [15:0] DELAY_MIN_RESET = 16'd150;
    localparam logic [15:0] DELAY_MAX_RESET = 16'd450;

    localparam logic CFG_DELAY_MIN = 1'b0;
    localparam logic CFG_DELAY_MAX = 1'b1;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_SUPPRESS = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    typedef enum logic [2:0] {
        OUT_SCHEDULED  = 3'd0,
        OUT_IGNORED    = 3'd1,
        OUT_SUPPRESSED = 3'd2,
        OUT_NO_MATCH   = 3'd3,
        OUT_FIRED      = 3'd4,
        OUT_NONE_DUE   = 3'd5,
        OUT_BAD_SENDER = 3'd6
    } rss_outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_WRITE,
        ST_EMIT,
        ST_SCAN
    } rss_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  sender_id;
        logic [15:0] beacon_seq;
        logic [31:0] time_now_ms;
        logic [31:0] random_word;
        logic [31:0] beacon_handle;
    } rss_in_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  out_sender_id;
        logic [15:0] out_seq;
        logic [31:0] out_handle;
        logic        last;
    } rss_out_t;

    typedef struct packed {
        logic         load;
        logic         div_start;
        logic         slot_write;
        logic         supp_clear;
        logic         scan_clear;
        logic         scan_inc;
        logic         fire;
        logic         emit;
        rss_outcome_t outcome;
    } rss_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       bad_sender;
        logic       older;
        logic       match;
        logic       div_done;
        logic       due_here;
        logic       fire_last;
        logic       idx_end;
        logic       out_free;
    } rss_status_t;

endpackage

`default_nettype wire

>>> hdl/rss_div.sv
`default_nettype none

module rss_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             done,
    output logic [16:0]      rem
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [rss_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [31:0]                    quo_reg;
    logic [31:0]                    quo_next;
    logic [16:0]                    rem_reg;
    logic [16:0]                    rem_next;
    logic [16:0]                    div_reg;

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb
    begin
        logic [17:0] r;
        logic [31:0] q;
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int k = 0; k < rss_pkg::DIV_BITS; k++)
        begin
            r = {r[16:0], q[31]};
            q = {q[30:0], 1'b0};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[16:0];
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start
                        && (cnt_reg == rss_pkg::DIV_CNT_W'(rss_pkg::DIV_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rss_pkg::DIV_CNT_W'(rss_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("remainder done without a running division");

endmodule

`default_nettype wire

>>> hdl/rss_dp.sv
`default_nettype none

module rss_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rss_pkg::rss_in_t  in_data,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [15:0]       cfg_wdata,
    input  wire rss_pkg::rss_cmd_t cmd,
    output rss_pkg::rss_status_t   st,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rss_pkg::rss_out_t      out_data
);

    localparam int SW = rss_pkg::SLOT_W;
    localparam int NS = rss_pkg::NUM_SLOTS;

    logic [15:0]            delay_min_reg;
    logic [15:0]            delay_max_reg;
    rss_pkg::rss_in_t       req_reg;
    logic [NS-1:0]          pending_reg;
    logic [15:0]            slot_seq_mem    [NS];
    logic [31:0]            slot_due_mem    [NS];
    logic [31:0]            slot_handle_mem [NS];
    logic [SW-1:0]          scan_idx_reg;
    logic [rss_pkg::CNT_W-1:0] fire_cnt_reg;
    logic                   out_valid_reg;
    rss_pkg::rss_out_t      out_data_reg;

    logic [SW-1:0]          sidx;
    logic [15:0]            cur_seq;
    logic [15:0]            seq_diff;
    logic                   newer;
    logic [15:0]            hi;
    logic [16:0]            span;
    logic                   div_done;
    logic [16:0]            div_rem;
    logic [31:0]            due_sum;
    logic [NS-1:0]          due_vec;
    logic                   higher_due;
    logic                   out_free;

    assign sidx     = req_reg.sender_id[SW-1:0];
    assign cur_seq  = slot_seq_mem[sidx];
    assign seq_diff = req_reg.beacon_seq - cur_seq;
    assign newer    = (seq_diff != 16'd0) && !seq_diff[15];

    assign hi   = (delay_max_reg < delay_min_reg) ? delay_min_reg : delay_max_reg;
    assign span = {1'b0, hi} - {1'b0, delay_min_reg} + 17'd1;

    rss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (req_reg.random_word),
        .divisor  (span),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign due_sum = req_reg.time_now_ms + {16'd0, delay_min_reg} + {15'd0, div_rem};

    // due when pending and now - due is not negative
    always_comb
    begin
        higher_due = 1'b0;
        for (int i = 0; i < NS; i++)
        begin
            logic [31:0] d;
            d = req_reg.time_now_ms - slot_due_mem[i];
            due_vec[i] = pending_reg[i] && !d[31];
            if (due_vec[i] && (SW'(i) > scan_idx_reg))
            begin
                higher_due = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st            = '0;
        st.opcode     = req_reg.opcode;
        st.bad_sender = ({1'b0, req_reg.sender_id} >= 9'(NS));
        st.older      = pending_reg[sidx] && !newer;
        st.match      = pending_reg[sidx] && (cur_seq == req_reg.beacon_seq);
        st.div_done   = div_done;
        st.due_here   = due_vec[scan_idx_reg];
        st.fire_last  = !higher_due
                        || (fire_cnt_reg == rss_pkg::CNT_W'(rss_pkg::MAX_RESULTS - 1));
        st.idx_end    = (scan_idx_reg == SW'(NS - 1));
        st.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_min_reg <= rss_pkg::DELAY_MIN_RESET;
            delay_max_reg <= rss_pkg::DELAY_MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                rss_pkg::CFG_DELAY_MIN: delay_min_reg <= cfg_wdata;
                rss_pkg::CFG_DELAY_MAX: delay_max_reg <= cfg_wdata;
                default:                delay_min_reg <= delay_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.slot_write)
        begin
            slot_seq_mem[sidx]    <= req_reg.beacon_seq;
            slot_handle_mem[sidx] <= req_reg.beacon_handle;
            slot_due_mem[sidx]    <= due_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            scan_idx_reg  <= '0;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.slot_write)
            begin
                pending_reg[sidx] <= 1'b1;
            end
            else if (cmd.supp_clear)
            begin
                pending_reg[sidx] <= 1'b0;
            end
            else if (cmd.fire)
            begin
                pending_reg[scan_idx_reg] <= 1'b0;
            end

            if (cmd.scan_clear)
            begin
                scan_idx_reg <= '0;
                fire_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.scan_inc)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (cmd.fire)
                begin
                    fire_cnt_reg <= fire_cnt_reg + 1'b1;
                end
            end

            if (cmd.fire || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            out_data_reg.outcome       <= rss_pkg::OUT_FIRED;
            out_data_reg.out_sender_id <= {{(8 - SW){1'b0}}, scan_idx_reg};
            out_data_reg.out_seq       <= slot_seq_mem[scan_idx_reg];
            out_data_reg.out_handle    <= slot_handle_mem[scan_idx_reg];
            out_data_reg.last          <= st.fire_last;
        end
        else if (cmd.emit)
        begin
            out_data_reg.outcome    <= cmd.outcome;
            out_data_reg.out_handle <= '0;
            out_data_reg.last       <= 1'b1;
            if (cmd.outcome == rss_pkg::OUT_NONE_DUE)
            begin
                out_data_reg.out_sender_id <= '0;
                out_data_reg.out_seq       <= '0;
            end
            else
            begin
                out_data_reg.out_sender_id <= req_reg.sender_id;
                out_data_reg.out_seq       <= req_reg.beacon_seq;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n) (cmd.fire || cmd.emit) |-> out_free)
        else $error("result loaded over an untaken result");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.fire |-> due_vec[scan_idx_reg])
        else $error("fired a slot that is not due");

endmodule

`default_nettype wire

>>> hdl/rss_ctrl.sv
`default_nettype none

module rss_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rss_pkg::rss_status_t st,
    output rss_pkg::rss_cmd_t         cmd
);

    rss_pkg::rss_state_t   state_reg;
    rss_pkg::rss_state_t   state_next;
    rss_pkg::rss_outcome_t outcome_reg;
    rss_pkg::rss_outcome_t outcome_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rss_pkg::ST_IDLE;
            outcome_reg <= rss_pkg::OUT_SCHEDULED;
        end
        else
        begin
            state_reg   <= state_next;
            outcome_reg <= outcome_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        outcome_next = outcome_reg;
        cmd          = '0;
        cmd.outcome  = outcome_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            rss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rss_pkg::ST_DECODE;
                end
            end

            rss_pkg::ST_DECODE:
            begin
                unique case (st.opcode)
                    rss_pkg::OP_SCHEDULE:
                    begin
                        if (st.bad_sender)
                        begin
                            outcome_next = rss_pkg::OUT_BAD_SENDER;
                            state_next   = rss_pkg::ST_EMIT;
                        end
                        else if (st.older)
                        begin
                            outcome_next = rss_pkg::OUT_IGNORED;
                            state_next   = rss_pkg::ST_EMIT;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = rss_pkg::ST_DIV;
                        end
                    end
                    rss_pkg::OP_SUPPRESS:
                    begin
                        state_next = rss_pkg::ST_EMIT;
                        if (st.bad_sender)
                        begin
                            outcome_next = rss_pkg::OUT_BAD_SENDER;
                        end
                        else if (st.match)
                        begin
                            cmd.supp_clear = 1'b1;
                            outcome_next   = rss_pkg::OUT_SUPPRESSED;
                        end
                        else
                        begin
                            outcome_next = rss_pkg::OUT_NO_MATCH;
                        end
                    end
                    rss_pkg::OP_TICK:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = rss_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        // unused opcode: drop without a result
                        state_next = rss_pkg::ST_IDLE;
                    end
                endcase
            end

            rss_pkg::ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = rss_pkg::ST_WRITE;
                end
            end

            rss_pkg::ST_WRITE:
            begin
                cmd.slot_write = 1'b1;
                outcome_next   = rss_pkg::OUT_SCHEDULED;
                state_next     = rss_pkg::ST_EMIT;
            end

            rss_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rss_pkg::ST_IDLE;
                end
            end

            rss_pkg::ST_SCAN:
            begin
                if (st.due_here)
                begin
                    // hold the slot until the result register frees up
                    if (st.out_free)
                    begin
                        cmd.fire = 1'b1;
                        if (st.fire_last)
                        begin
                            state_next = rss_pkg::ST_IDLE;
                        end
                        else
                        begin
                            cmd.scan_inc = 1'b1;
                        end
                    end
                end
                else if (st.idx_end)
                begin
                    // a fired slot before the end would have been the last one
                    outcome_next = rss_pkg::OUT_NONE_DUE;
                    state_next   = rss_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end

            default:
            begin
                state_next = rss_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == rss_pkg::ST_DIV))
        else $error("division started outside the schedule path");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rss_pkg::ST_DIV && st.div_done) |=> cmd.slot_write)
        else $error("slot not written after the delay was drawn");

endmodule

`default_nettype wire

>>> hdl/relay_suppression_scheduler.sv
// Channel  Direction  Handshake              Payload
// in       request    in_valid / in_ready    in_data  (rss_in_t)
// out      result     out_valid / out_ready  out_data (rss_out_t)
// cfg      write      cfg_wr_en              cfg_addr, cfg_wdata
//
// One request at a time. Suppress, bad sender and older schedule: decode, emit.
// Schedule: decode, remainder unit (4 bits per cycle), write, emit.
// Tick: scans the slots in index order, one result per due slot,
// or a none-due result when nothing is due.
// Reset clears the pending flags; no clearing pass is needed.
// A full result register stalls only the step that produces a result.
`default_nettype none

module relay_suppression_scheduler (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rss_pkg::rss_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rss_pkg::rss_out_t     out_data,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_addr,
    input  wire logic [15:0]      cfg_wdata
);

    rss_pkg::rss_cmd_t    cmd;
    rss_pkg::rss_status_t st;

    rss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    rss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> dv/relay_suppression_scheduler_tb.sv
module relay_suppression_scheduler_tb;
    import rss_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 20;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Predicts the result stream of the relay scheduler and checks it in order.
    class relay_scoreboard;
        logic [15:0] delay_lo;
        logic [15:0] delay_hi;
        bit          pending[NUM_SLOTS];
        logic [15:0] seq_of[NUM_SLOTS];
        logic [31:0] due_of[NUM_SLOTS];
        logic [31:0] handle_of[NUM_SLOTS];
        rss_out_t    expected_q[$];
        int          errors;

        function new();
            delay_lo = DELAY_MIN_RESET;
            delay_hi = DELAY_MAX_RESET;
            errors   = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pending[i]   = 1'b0;
                seq_of[i]    = '0;
                due_of[i]    = '0;
                handle_of[i] = '0;
            end
        endfunction

        function void set_reg(logic addr, logic [15:0] val);
            if (addr == CFG_DELAY_MIN)
                delay_lo = val;
            else
                delay_hi = val;
        endfunction

        function void push(rss_outcome_t oc, int sender, logic [15:0] seq,
                           logic [31:0] handle, bit last);
            rss_out_t r;
            r.outcome       = oc;
            r.out_sender_id = sender[7:0];
            r.out_seq       = seq;
            r.out_handle    = handle;
            r.last          = last;
            expected_q.push_back(r);
        endfunction

        function logic [31:0] draw_delay_ms(logic [31:0] rnd);
            logic [31:0] top;
            logic [31:0] span;
            top  = (delay_hi < delay_lo) ? {16'd0, delay_lo} : {16'd0, delay_hi};
            span = top - {16'd0, delay_lo} + 32'd1;
            return {16'd0, delay_lo} + (rnd % span);
        endfunction

        function void note_request(rss_in_t req);
            int          s;
            int          n;
            logic [15:0] seq_gap;
            rss_out_t    tail;
            s = req.sender_id;
            if (req.opcode == OP_SCHEDULE || req.opcode == OP_SUPPRESS)
            begin
                if (s >= NUM_SLOTS)
                    push(OUT_BAD_SENDER, s, req.beacon_seq, '0, 1'b1);
                else if (req.opcode == OP_SCHEDULE)
                begin
                    seq_gap = req.beacon_seq - seq_of[s];
                    if (pending[s] && !(seq_gap != 16'd0 && seq_gap < 16'h8000))
                        push(OUT_IGNORED, s, req.beacon_seq, '0, 1'b1);
                    else
                    begin
                        pending[s]   = 1'b1;
                        seq_of[s]    = req.beacon_seq;
                        handle_of[s] = req.beacon_handle;
                        due_of[s]    = req.time_now_ms + draw_delay_ms(req.random_word);
                        push(OUT_SCHEDULED, s, req.beacon_seq, '0, 1'b1);
                    end
                end
                else if (pending[s] && seq_of[s] == req.beacon_seq)
                begin
                    pending[s] = 1'b0;
                    push(OUT_SUPPRESSED, s, req.beacon_seq, '0, 1'b1);
                end
                else
                    push(OUT_NO_MATCH, s, req.beacon_seq, '0, 1'b1);
            end
            else if (req.opcode == OP_TICK)
            begin
                n = 0;
                for (int i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++)
                begin
                    // due once now - due is not negative as a signed 32-bit value
                    if (pending[i] && !((req.time_now_ms - due_of[i]) & 32'h8000_0000))
                    begin
                        pending[i] = 1'b0;
                        push(OUT_FIRED, i, seq_of[i], handle_of[i], 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    push(OUT_NONE_DUE, 0, '0, '0, 1'b1);
                else
                begin
                    tail = expected_q.pop_back();
                    tail.last = 1'b1;
                    expected_q.push_back(tail);
                end
            end
        endfunction

        function void check_result(rss_out_t got);
            rss_out_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result %0d/%0d/%h/%h/%b", $time,
                             got.outcome, got.out_sender_id, got.out_seq,
                             got.out_handle, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.outcome !== want.outcome || got.out_sender_id !== want.out_sender_id ||
                got.out_seq !== want.out_seq || got.out_handle !== want.out_handle ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch expected %0d/%0d/%h/%h/%b actual %0d/%0d/%h/%h/%b",
                             $time, want.outcome, want.out_sender_id, want.out_seq,
                             want.out_handle, want.last, got.outcome, got.out_sender_id,
                             got.out_seq, got.out_handle, got.last);
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    rss_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rss_out_t    out_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = '0;

    relay_scoreboard sb = new();
    bit          hold_off_req = 1'b0;
    logic [31:0] cur_now = '0;
    int          cycles = 0;

    relay_suppression_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // result side: stall pattern of its own, plus one long hold-off on request
    initial
    begin
        int mode;
        int cnt;
        mode = 0;
        cnt  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (cnt % 48 == 0)
                    mode = $urandom_range(0, 2);
                cnt++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (cnt % 5 == 0);
                endcase
            end
        end
    end

    function automatic rss_in_t req_of(logic [1:0] op, int sender, logic [15:0] seq,
                                       logic [31:0] now, logic [31:0] rnd,
                                       logic [31:0] handle);
        rss_in_t r;
        r.opcode        = op;
        r.sender_id     = sender[7:0];
        r.beacon_seq    = seq;
        r.time_now_ms   = now;
        r.random_word   = rnd;
        r.beacon_handle = handle;
        return r;
    endfunction

    function automatic rss_in_t make_request();
        rss_in_t     r;
        int          pick;
        int          s;
        int          span;
        int          kind;
        logic [15:0] base;
        pick = $urandom_range(0, 99);
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_SLOTS, 255)
                                        : $urandom_range(0, NUM_SLOTS - 1);
        if (s < NUM_SLOTS)
            base = sb.seq_of[s];
        else
            base = 16'($urandom);
        kind = $urandom_range(0, 99);
        r = req_of(OP_SCHEDULE, s, base, cur_now, $urandom, $urandom);
        if (pick < 45)
        begin
            cur_now += $urandom_range(0, 3);
            r.time_now_ms = cur_now;
            if (kind < 60)
                r.beacon_seq = base + 16'($urandom_range(1, 40));
            else if (kind < 90 && kind >= 75)
                r.beacon_seq = base - 16'($urandom_range(1, 40));
            else if (kind >= 90 && kind < 95)
                r.beacon_seq = base + 16'h8000;
            else if (kind >= 95)
                r.beacon_seq = 16'($urandom);
        end
        else if (pick < 70)
        begin
            r.opcode = OP_SUPPRESS;
            if (kind >= 60)
                r.beacon_seq = 16'($urandom);
        end
        else if (pick < 97)
        begin
            span = ((sb.delay_hi > sb.delay_lo) ? sb.delay_hi : sb.delay_lo) / 2 + 3;
            cur_now += $urandom_range(0, span);
            r.opcode      = OP_TICK;
            r.time_now_ms = cur_now;
        end
        else
        begin
            r.opcode      = OP_UNUSED;
            r.time_now_ms = $urandom;
        end
        return r;
    endfunction

    task automatic send_request(input rss_in_t req);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic idle_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic wait_all_results();
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // write only with the block drained; a trailing unused opcode may still be in work
    task automatic apply_delays(input logic [15:0] lo, input logic [15:0] hi);
        idle_sender(1);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_DELAY_MIN;
        cfg_wdata <= lo;
        sb.set_reg(CFG_DELAY_MIN, lo);
        @(negedge clk);
        cfg_addr  <= CFG_DELAY_MAX;
        cfg_wdata <= hi;
        sb.set_reg(CFG_DELAY_MAX, hi);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        send_request(req_of(OP_TICK, 0, 16'h0000, 32'd0, 32'd0, 32'd0));
        send_request(req_of(OP_SCHEDULE, 0, 16'h0000, 32'd0, 32'd0, 32'd0));
        // equal and half-circle sequences are not newer
        send_request(req_of(OP_SCHEDULE, 0, 16'h0000, 32'd5, 32'd1, 32'd1));
        send_request(req_of(OP_SCHEDULE, 0, 16'h8000, 32'd5, 32'd1, 32'd1));
        send_request(req_of(OP_SCHEDULE, 0, 16'h7FFF, '1, '1, '1));
        send_request(req_of(OP_SUPPRESS, 0, 16'h0001, 32'd0, 32'd0, 32'd0));
        send_request(req_of(OP_SUPPRESS, 0, 16'h7FFF, 32'd0, 32'd0, 32'd0));
        send_request(req_of(OP_SUPPRESS, 0, 16'h7FFF, 32'd0, 32'd0, 32'd0));
        send_request(req_of(OP_SCHEDULE, 255, 16'hFFFF, '1, '1, '1));
        send_request(req_of(OP_SUPPRESS, NUM_SLOTS, 16'hFFFF, '1, '1, '1));
        send_request(req_of(OP_UNUSED, 255, 16'hFFFF, '1, '1, '1));
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(req_of(OP_SCHEDULE, i, 16'($urandom), 32'd1000, $urandom, $urandom));
        send_request(req_of(OP_TICK, 0, 16'h0000, 32'd1100, 32'd0, 32'd0));
        // every slot still pending is due at once
        send_request(req_of(OP_TICK, 0, 16'h0000, 32'd1450, 32'd0, 32'd0));
    endtask

    task automatic run_random(input int n_items, input bit hold_rx);
        int      sent;
        int      burst;
        rss_in_t req;
        sent = 0;
        if (hold_rx)
            hold_off_req = 1'b1;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < n_items)
            begin
                req = make_request();
                send_request(req);
                if (req.opcode != OP_UNUSED)
                    sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        apply_delays(16'd0, 16'd0);
        cur_now = $urandom;
        run_random(26, 1'b0);

        apply_delays(16'd0, 16'hFFFF);
        cur_now = $urandom;
        run_random(26, 1'b1);

        // hold the time base just below the wrap
        apply_delays(16'hFFFF, 16'hFFFF);
        cur_now = 32'hFFFF_0000;
        run_random(26, 1'b0);

        // max below min: delay is exactly min
        apply_delays(16'd300, 16'd20);
        cur_now = $urandom;
        run_random(26, 1'b0);

        apply_delays(16'd7, 16'd60);
        cur_now = $urandom;
        run_random(26, 1'b0);

        idle_sender(1);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rss_pkg.sv
hdl/rss_div.sv
hdl/rss_dp.sv
hdl/rss_ctrl.sv
hdl/relay_suppression_scheduler.sv
dv/relay_suppression_scheduler_tb.sv
